// File: sv/fdns_pkg.sv
package fdns_pkg;

  // store depth and coordinate width
  localparam int unsigned MAX_ATOMS = 4096;
  localparam int unsigned COORD_W   = 24;

  // store address and frame atom counter (counter can hold MAX_ATOMS itself)
  localparam int unsigned ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ATOMS + 1);

  // result fields
  localparam int unsigned PAIR_W = 20;
  localparam int unsigned SUM_W  = 48;

  // norm datapath: abs difference, square, root
  localparam int unsigned ABS_W  = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * ABS_W;
  localparam int unsigned ROOT_W = ABS_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // stream words
  localparam int unsigned IN_DATA_W  = ((3 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((PAIR_W + SUM_W + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one classified atom handed from front to back
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t cur_z;
    coord_t prv_x;
    coord_t prv_y;
    coord_t prv_z;
    logic   do_sum;  // atom in store range and a previous frame exists
    logic   oob;     // atom beyond store depth
    logic   last;    // atom closes its frame
    logic   emit;    // frame end that produces a result
  } entry_t;

endpackage

// File: sv/frame_displacement_norm_sum_top.sv
// sums, over each trajectory frame, the euclidean displacement of every atom from its
// position in the previous frame. one word on the slave side is one atom (x, y, z in
// signed q15.8, tlast on the frame's final atom); one word on the master side is one
// result per finished frame pair: the pair index, the saturating q40.8 sum and an
// overflow flag set when the frame held more atoms than the 4096-entry position store
// or the sum clamped. the very first frame only fills the store and gives no word.
// an atom whose displacement is summed passes in the back end through three squares on one
// shared multiplier, a 25-step bit-serial square root and one accumulate; an atom of the
// first frame or beyond the store skips all three. the front end reads the store and
// queues up to four classified atoms ahead of the back end, and the result sits in an
// output register, so a stalled master side holds the back end only when a second
// result is ready. the position store has no reset: an atom slot never written before
// it is read gives an undefined displacement
module frame_displacement_norm_sum_top
  import fdns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side: atoms
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic                  s_axis_tlast,   // last_atom
  // master side: frame pair results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pair_index, distance_sum, zero pad
  output logic                  m_axis_tuser    // overflow
);

  entry_t            push_data, pop_data;
  logic              push, full, pop, fifo_valid;
  logic [PAIR_W-1:0] pair_index;
  logic [SUM_W-1:0]  distance_sum;
  logic              overflow;

  // front: accept, look up the previous position, classify
  fdns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_x_i     (s_axis_tdata[COORD_W-1:0]),
    .pos_y_i     (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .pos_z_i     (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .last_atom_i (s_axis_tlast),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // short queue decoupling lookup from the norm unit
  fdns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .valid_o (fifo_valid)
  );

  // back: norm, running sum, frame results
  fdns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (pop_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pair_o   (pair_index),
    .out_sum_o    (distance_sum),
    .out_ovf_o    (overflow)
  );

  // result word, pair index in the lowest bits
  assign m_axis_tdata = {{(OUT_DATA_W - PAIR_W - SUM_W){1'b0}}, distance_sum, pair_index};
  assign m_axis_tuser = overflow;

endmodule

// File: sv/fdns_ram.sv
module fdns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fdns_front.sv
module fdns_front
  import fdns_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  coord_t pos_x_i,
  input  coord_t pos_y_i,
  input  coord_t pos_z_i,
  input  logic   last_atom_i,
  output logic   push_o,
  output entry_t push_data_o,
  input  logic   full_i
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             have_prev_q, have_prev_d;
  logic             s1_valid_q, s1_valid_d;
  coord_t           s1_x_q, s1_y_q, s1_z_q;
  logic             s1_do_sum_q, s1_oob_q, s1_last_q, s1_emit_q;
  logic             accept;
  logic             in_range;
  logic [3*COORD_W-1:0] rdata;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = cnt_q < CNT_W'(MAX_ATOMS);

  fdns_ram #(
    .WIDTH (3 * COORD_W),
    .DEPTH (MAX_ATOMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && in_range),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .re_i    (accept),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    s1_valid_d  = s1_valid_q;
    if (s1_valid_q && !full_i) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      if (last_atom_i) begin
        cnt_d       = '0;
        have_prev_d = 1'b1;
      end else if (in_range) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  // classification travels with the atom, previous position arrives from the store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q      <= pos_x_i;
      s1_y_q      <= pos_y_i;
      s1_z_q      <= pos_z_i;
      s1_do_sum_q <= in_range && have_prev_q;
      s1_oob_q    <= !in_range;
      s1_last_q   <= last_atom_i;
      s1_emit_q   <= last_atom_i && have_prev_q;
    end
  end

  assign push_o = s1_valid_q && !full_i;

  always_comb begin
    push_data_o.cur_x  = s1_x_q;
    push_data_o.cur_y  = s1_y_q;
    push_data_o.cur_z  = s1_z_q;
    push_data_o.prv_x  = rdata[COORD_W-1:0];
    push_data_o.prv_y  = rdata[2*COORD_W-1:COORD_W];
    push_data_o.prv_z  = rdata[3*COORD_W-1:2*COORD_W];
    push_data_o.do_sum = s1_do_sum_q;
    push_data_o.oob    = s1_oob_q;
    push_data_o.last   = s1_last_q;
    push_data_o.emit   = s1_emit_q;
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ATOMS))
    else $error("atom counter beyond store depth");

  a_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (!(s1_emit_q && !s1_last_q) && !(s1_do_sum_q && s1_oob_q)))
    else $error("inconsistent atom classification");

endmodule

// File: sv/fdns_fifo.sv
module fdns_fifo
  import fdns_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   valid_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  entry_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = count_q == (PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

// File: sv/fdns_back.sv
module fdns_back
  import fdns_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  entry_t            fifo_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PAIR_W-1:0] out_pair_o,
  output logic [SUM_W-1:0]  out_sum_o,
  output logic              out_ovf_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_ACC,
    ST_FIN
  } state_e;

  localparam int unsigned RCNT_W   = $clog2(ROOT_W);
  localparam logic [1:0]  SEL_LAST = 2'd3;

  state_e              state_q;
  entry_t              ent_q;
  logic [1:0]          sel_q;
  logic [SQ_W-1:0]     sq_q, acc_q, rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [RCNT_W-1:0]   bit_cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic                ovf_q;
  logic [PAIR_W-1:0]   pair_q;
  logic                out_valid_q;
  logic [PAIR_W-1:0]   out_pair_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                out_ovf_q;

  coord_t              cur_sel, prv_sel;
  logic signed [ABS_W-1:0] dif;
  logic [ABS_W-1:0]    abs_v;
  logic [SQ_W-1:0]     sq_d;
  logic [REM_W-1:0]    rem_sh, trial, rem_d;
  logic                ge;
  logic [SUM_W:0]      sum_ext;
  logic                ovf_eff;
  logic                out_free;
  logic                out_load;

  // one axis a cycle through a single multiplier
  always_comb begin
    unique case (sel_q)
      2'd0: begin
        cur_sel = ent_q.cur_x;
        prv_sel = ent_q.prv_x;
      end
      2'd1: begin
        cur_sel = ent_q.cur_y;
        prv_sel = ent_q.prv_y;
      end
      default: begin
        cur_sel = ent_q.cur_z;
        prv_sel = ent_q.prv_z;
      end
    endcase
    dif   = ABS_W'(cur_sel) - ABS_W'(prv_sel);
    abs_v = dif[ABS_W-1] ? ABS_W'(-dif) : ABS_W'(dif);
    sq_d  = SQ_W'(abs_v) * SQ_W'(abs_v);
  end

  // restoring square root, one result bit a cycle
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
  end

  assign sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(root_q);
  assign ovf_eff  = ovf_q || ent_q.oob;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_FIN) && ent_q.last && ent_q.emit && out_free;
  assign pop_o    = (state_q == ST_IDLE) && fifo_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ent_q       <= '0;
      sel_q       <= '0;
      sq_q        <= '0;
      acc_q       <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      bit_cnt_q   <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
      out_pair_q  <= '0;
      out_sum_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (fifo_valid_i) begin
            ent_q <= fifo_data_i;
            sel_q <= '0;
            acc_q <= '0;
            state_q <= fifo_data_i.do_sum ? ST_SQ : ST_FIN;
          end
        end
        ST_SQ: begin
          if (sel_q != SEL_LAST) begin
            sq_q <= sq_d;
          end
          if (sel_q != 2'd0) begin
            acc_q <= acc_q + sq_q;
          end
          sel_q <= sel_q + 1'b1;
          if (sel_q == SEL_LAST) begin
            rad_q     <= acc_q + sq_q;
            rem_q     <= '0;
            root_q    <= '0;
            bit_cnt_q <= RCNT_W'(ROOT_W - 1);
            state_q   <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rem_q  <= rem_d;
          root_q <= {root_q[ROOT_W-2:0], ge};
          rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
          if (bit_cnt_q == '0) begin
            state_q <= ST_ACC;
          end else begin
            bit_cnt_q <= bit_cnt_q - 1'b1;
          end
        end
        ST_ACC: begin
          if (sum_ext[SUM_W]) begin
            sum_q <= '1;
            ovf_q <= 1'b1;
          end else begin
            sum_q <= sum_ext[SUM_W-1:0];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!ent_q.last) begin
            ovf_q   <= ovf_eff;
            state_q <= ST_IDLE;
          end else if (!ent_q.emit || out_free) begin
            if (ent_q.emit) begin
              out_pair_q  <= pair_q;
              out_sum_q   <= sum_q;
              out_ovf_q   <= ovf_eff;
              pair_q      <= pair_q + 1'b1;
            end
            sum_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pair_o  = out_pair_q;
  assign out_sum_o   = out_sum_q;
  assign out_ovf_o   = out_ovf_q;

  a_root_only_summed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT || state_q == ST_ACC) |-> ent_q.do_sum)
    else $error("norm computed for an atom that is not summed");

endmodule

// File: dv/testbench.sv
// self-checking bench for frame_displacement_norm_sum_top
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdns_pkg::*;

  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 4000;
  // cycles the master side is held off once thirty results have been checked
  localparam int unsigned HOLD_OFF = 600;
  localparam int unsigned RAND_ATOMS = 340;
  // at least as long as any later frame, so every slot read was written before
  localparam int unsigned FIRST_ATOMS = 40;

  localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_ZERO = '0;
  localparam logic [COORD_W-1:0] C_ONE  = COORD_W'(1);
  localparam logic [COORD_W-1:0] C_NEG1 = '1;

  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    logic              ovf;
  } pair_result_t;

  // predicts one result word per frame pair and checks the words that come out
  class displacement_scoreboard;
    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;

    logic [COORD_W-1:0] prev_x [MAX_ATOMS];
    logic [COORD_W-1:0] prev_y [MAX_ATOMS];
    logic [COORD_W-1:0] prev_z [MAX_ATOMS];
    int unsigned        atom_idx;
    bit                 have_prev;
    longint unsigned    frame_sum;
    logic [PAIR_W-1:0]  pair_idx;
    bit                 frame_ovf;
    pair_result_t       expected_pairs [$];
    int unsigned        errors;
    int unsigned        results_checked;

    function new();
      atom_idx        = 0;
      have_prev       = 0;
      frame_sum       = 0;
      pair_idx        = '0;
      frame_ovf       = 0;
      errors          = 0;
      results_checked = 0;
    endfunction

    // squared distance along one axis, exact
    function longint unsigned axis_sq(logic [COORD_W-1:0] cur, logic [COORD_W-1:0] old);
      longint a;
      longint b;
      longint d;
      a = $signed(cur);
      b = $signed(old);
      d = a - b;
      if (d < 0) d = -d;
      return longint'(d * d);
    endfunction

    // largest r with r*r <= v
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_atom(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic last);
      longint unsigned sq;
      longint unsigned norm;
      pair_result_t    res;
      if (atom_idx < MAX_ATOMS) begin
        if (have_prev) begin
          sq = axis_sq(x, prev_x[atom_idx]) + axis_sq(y, prev_y[atom_idx]) +
               axis_sq(z, prev_z[atom_idx]);
          norm = floor_root(sq);
          if (norm > SUM_CAP - frame_sum) begin
            frame_sum = SUM_CAP;
            frame_ovf = 1;
          end else begin
            frame_sum += norm;
          end
        end
        prev_x[atom_idx] = x;
        prev_y[atom_idx] = y;
        prev_z[atom_idx] = z;
        atom_idx++;
      end else begin
        // beyond the store: dropped, only flagged
        frame_ovf = 1;
      end
      if (last) begin
        if (have_prev) begin
          res.pair = pair_idx;
          res.sum  = frame_sum[SUM_W-1:0];
          res.ovf  = frame_ovf;
          expected_pairs.push_back(res);
          pair_idx++;
        end
        have_prev = 1;
        frame_sum = 0;
        atom_idx  = 0;
        frame_ovf = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: %s", $realtime, msg);
      errors++;
    endtask

    task check_pair_result(logic [PAIR_W-1:0] pair, logic [SUM_W-1:0] sum, logic ovf);
      pair_result_t want;
      results_checked++;
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: pair %0d sum 0x%0h ovf %0b",
                                  pair, sum, ovf));
      end else begin
        want = expected_pairs.pop_front();
        if (pair !== want.pair)
          report_mismatch($sformatf("pair_index got %0d expected %0d", pair, want.pair));
        if (sum !== want.sum)
          report_mismatch($sformatf("distance_sum of pair %0d got 0x%0h expected 0x%0h",
                                    want.pair, sum, want.sum));
        if (ovf !== want.ovf)
          report_mismatch($sformatf("overflow of pair %0d got %0b expected %0b",
                                    want.pair, ovf, want.ovf));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  displacement_scoreboard sb = new();
  bit                     src_quiet;
  int unsigned            stall_cycles = 0;

  frame_displacement_norm_sum_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // extremes, zero, full-range noise and small values near the origin
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = C_MAX;
      1:       v = C_MIN;
      2:       v = C_ZERO;
      3, 4, 5: v = COORD_W'($urandom());
      default: v = COORD_W'($urandom_range(0, 4095) - 2048);
    endcase
    return v;
  endfunction

  // offers one atom word from a falling edge and returns on the falling edge after it
  task automatic send_atom(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic last);
    int gap;
    gap = src_quiet ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_DATA_W'({z, y, x});
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_atom(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  // result words checked before the atom words of the same edge are noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_pair_result(m_axis_tdata[PAIR_W-1:0], m_axis_tdata[PAIR_W +: SUM_W],
                             m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_atom(s_axis_tdata[0 +: COORD_W], s_axis_tdata[COORD_W +: COORD_W],
                     s_axis_tdata[2*COORD_W +: COORD_W], s_axis_tlast);
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL frame_displacement_norm_sum_top");
      $finish;
    end
  end

  // master side: random stalls, calm stretches and one long hold-off
  initial begin
    int hold;
    int calm;
    bit pressed;
    hold    = 0;
    calm    = 0;
    pressed = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      // hold off while the sender keeps offering, so the queue fills and the input stalls
      if (!pressed && sb.results_checked >= 30) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk_i);
        pressed = 1;
      end
      if (calm > 0) begin
        calm--;
        m_axis_tready = 1'b1;
      end else if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 49) == 0)
          calm = 200;
        else if ($urandom_range(0, 3) == 0)
          hold = idle_len();
      end
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int          r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_quiet     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first frame covers every slot a later frame reads; it gives no word
    send_random_frame(FIRST_ATOMS);

    // single-atom frames: extremes, largest and zero displacement
    send_atom(C_ZERO, C_ZERO, C_ZERO, 1'b1);
    send_atom(C_MAX, C_MAX, C_MAX, 1'b1);
    send_atom(C_MIN, C_MIN, C_MIN, 1'b1);
    send_atom(C_MIN, C_MIN, C_MIN, 1'b1);
    send_atom(C_MAX, C_MIN, C_ZERO, 1'b1);
    send_atom(C_ZERO, C_MAX, C_MIN, 1'b1);
    // a short frame and a longer one, reusing slots the first frame left
    send_atom(C_ONE, C_ZERO, C_NEG1, 1'b0);
    send_atom(C_NEG1, C_NEG1, C_NEG1, 1'b0);
    send_atom(C_MAX, C_ZERO, C_MIN, 1'b1);
    send_atom(C_ONE, C_ONE, C_ONE, 1'b0);
    send_atom(C_MIN, C_MAX, C_ZERO, 1'b0);
    send_atom(C_ZERO, C_ZERO, C_ONE, 1'b0);
    send_atom(C_MAX, C_MAX, C_NEG1, 1'b0);
    send_atom(C_NEG1, C_MIN, C_MAX, 1'b1);

    // random frames, mostly short, some bursts without source gaps
    sent = 0;
    while (sent < RAND_ATOMS) begin
      r = $urandom_range(0, 99);
      if (r < 50)      len = $urandom_range(1, 4);
      else if (r < 90) len = $urandom_range(5, 12);
      else             len = $urandom_range(13, 40);
      src_quiet = ($urandom_range(0, 3) == 0);
      send_random_frame(len);
      sent += len;
    end
    src_quiet = 0;

    // a couple of closing frames
    send_random_frame(3);
    send_random_frame(1);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;

    while (sb.expected_pairs.size() != 0) @(posedge clk_i);
    // let any stray word show up
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS frame_displacement_norm_sum_top");
    end else begin
      $display("FAIL frame_displacement_norm_sum_top");
    end
    $finish;
  end

endmodule
